### src/plt_pkg.sv
package plt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int PEER_CAPACITY = TABLE_DEPTH;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W = 48;
    localparam int STR_W  = 8;
    localparam int SEEN_W = 32;
    localparam int ENTRY_W = ADDR_W + STR_W + SEEN_W;

    localparam int STATUS_W = 3;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_CMP,
        S_MISS,
        S_RDATA,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_UPDATED,
        RES_INSERTED,
        RES_FULL,
        RES_READ_OK,
        RES_READ_EMPTY
    } t_res;

    typedef struct packed {
        logic latch;
        logic rd;
        logic idx_inc;
        logic wr_hit;
        logic wr_new;
        t_res res;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic in_range;
        logic fill_zero;
        logic match;
        logic more;
        logic room;
        logic out_free;
    } t_stat;

endpackage

### src/plt_ram.sv
module plt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/plt_datapath.sv
module plt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plt_pkg::t_cmd                 i_cmd,
    output plt_pkg::t_stat                o_stat,
    input  logic                          i_op,
    input  logic [plt_pkg::ADDR_W-1:0]    i_addr,
    input  logic signed [plt_pkg::STR_W-1:0] i_str,
    input  logic [plt_pkg::SEEN_W-1:0]    i_seen,
    input  logic [plt_pkg::IDX_W-1:0]     i_ridx,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [plt_pkg::STATUS_W-1:0]  o_status,
    output logic [plt_pkg::IDX_W-1:0]     o_index,
    output logic [plt_pkg::ADDR_W-1:0]    o_addr,
    output logic signed [plt_pkg::STR_W-1:0] o_str,
    output logic [plt_pkg::SEEN_W-1:0]    o_seen,
    output logic [plt_pkg::FILL_W-1:0]    o_fill
);

    // latched item
    logic                                r_op;
    logic [plt_pkg::ADDR_W-1:0]          r_addr;
    logic signed [plt_pkg::STR_W-1:0]    r_str;
    logic [plt_pkg::SEEN_W-1:0]          r_seen;
    logic [plt_pkg::IDX_W-1:0]           r_idx;
    logic [plt_pkg::FILL_W-1:0]          r_fill;

    // result under construction
    logic [plt_pkg::STATUS_W-1:0]        r_p_status;
    logic [plt_pkg::IDX_W-1:0]           r_p_index;
    logic [plt_pkg::ADDR_W-1:0]          r_p_addr;
    logic signed [plt_pkg::STR_W-1:0]    r_p_str;
    logic [plt_pkg::SEEN_W-1:0]          r_p_seen;
    logic [plt_pkg::FILL_W-1:0]          r_p_fill;

    // output register
    logic                                r_o_valid;
    logic [plt_pkg::STATUS_W-1:0]        r_o_status;
    logic [plt_pkg::IDX_W-1:0]           r_o_index;
    logic [plt_pkg::ADDR_W-1:0]          r_o_addr;
    logic signed [plt_pkg::STR_W-1:0]    r_o_str;
    logic [plt_pkg::SEEN_W-1:0]          r_o_seen;
    logic [plt_pkg::FILL_W-1:0]          r_o_fill;

    logic [plt_pkg::IDX_W-1:0]           idx_next;
    logic [plt_pkg::FILL_W-1:0]          idx_ext;
    logic [plt_pkg::FILL_W-1:0]          idx_ext_next;
    logic [plt_pkg::IDX_W-1:0]           rd_addr;
    logic [plt_pkg::IDX_W-1:0]           wr_addr;
    logic [plt_pkg::ENTRY_W-1:0]         wr_data;
    logic [plt_pkg::ENTRY_W-1:0]         rd_data;
    logic [plt_pkg::ADDR_W-1:0]          rd_entry_addr;
    logic [plt_pkg::STR_W-1:0]           rd_entry_str;
    logic [plt_pkg::SEEN_W-1:0]          rd_entry_seen;

    assign idx_next     = r_idx + 1'b1;
    assign idx_ext      = {1'b0, r_idx};
    assign idx_ext_next = idx_ext + 1'b1;
    assign rd_addr      = i_cmd.idx_inc ? idx_next : r_idx;
    assign wr_addr      = i_cmd.wr_new ? r_fill[plt_pkg::IDX_W-1:0] : r_idx;
    assign wr_data      = {r_addr, r_str, r_seen};

    assign rd_entry_addr = rd_data[plt_pkg::ENTRY_W-1 -: plt_pkg::ADDR_W];
    assign rd_entry_str  = rd_data[plt_pkg::SEEN_W +: plt_pkg::STR_W];
    assign rd_entry_seen = rd_data[plt_pkg::SEEN_W-1:0];

    plt_ram #(
        .WIDTH (plt_pkg::ENTRY_W),
        .DEPTH (plt_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_hit | i_cmd.wr_new),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        o_stat.is_read   = (r_op == plt_pkg::OP_READ);
        o_stat.in_range  = (idx_ext < r_fill);
        o_stat.fill_zero = (r_fill == '0);
        o_stat.match     = (rd_entry_addr == r_addr);
        o_stat.more      = (idx_ext_next < r_fill);
        o_stat.room      = (r_fill < plt_pkg::FILL_W'(plt_pkg::TABLE_DEPTH));
        o_stat.out_free  = !r_o_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_op;
            r_addr <= i_addr;
            r_str  <= i_str;
            r_seen <= i_seen;
            r_idx  <= (i_op == plt_pkg::OP_READ) ? i_ridx : '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.wr_new) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // result fields per outcome
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.res)
            plt_pkg::RES_UPDATED: begin
                r_p_status <= plt_pkg::ST_UPDATED;
                r_p_index  <= r_idx;
                r_p_addr   <= r_addr;
                r_p_str    <= r_str;
                r_p_seen   <= r_seen;
                r_p_fill   <= r_fill;
            end
            plt_pkg::RES_INSERTED: begin
                r_p_status <= plt_pkg::ST_INSERTED;
                r_p_index  <= r_fill[plt_pkg::IDX_W-1:0];
                r_p_addr   <= r_addr;
                r_p_str    <= r_str;
                r_p_seen   <= r_seen;
                r_p_fill   <= r_fill + 1'b1;
            end
            plt_pkg::RES_FULL: begin
                r_p_status <= plt_pkg::ST_FULL;
                r_p_index  <= '0;
                r_p_addr   <= '0;
                r_p_str    <= '0;
                r_p_seen   <= '0;
                r_p_fill   <= r_fill;
            end
            plt_pkg::RES_READ_OK: begin
                r_p_status <= plt_pkg::ST_READ_OK;
                r_p_index  <= r_idx;
                r_p_addr   <= rd_entry_addr;
                r_p_str    <= rd_entry_str;
                r_p_seen   <= rd_entry_seen;
                r_p_fill   <= r_fill;
            end
            plt_pkg::RES_READ_EMPTY: begin
                r_p_status <= plt_pkg::ST_READ_EMPTY;
                r_p_index  <= r_idx;
                r_p_addr   <= '0;
                r_p_str    <= '0;
                r_p_seen   <= '0;
                r_p_fill   <= r_fill;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status <= r_p_status;
            r_o_index  <= r_p_index;
            r_o_addr   <= r_p_addr;
            r_o_str    <= r_p_str;
            r_o_seen   <= r_p_seen;
            r_o_fill   <= r_p_fill;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_index     = r_o_index;
    assign o_addr      = r_o_addr;
    assign o_str       = r_o_str;
    assign o_seen      = r_o_seen;
    assign o_fill      = r_o_fill;

endmodule

### src/plt_ctrl.sv
module plt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  plt_pkg::t_stat  i_stat,
    output plt_pkg::t_cmd   o_cmd
);

    plt_pkg::t_state r_state;
    plt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plt_pkg::S_IDLE: begin
                if (i_valid) n_state = plt_pkg::S_LOOK;
            end
            plt_pkg::S_LOOK: begin
                if (i_stat.is_read) begin
                    n_state = i_stat.in_range ? plt_pkg::S_RDATA : plt_pkg::S_DONE;
                end else begin
                    n_state = i_stat.fill_zero ? plt_pkg::S_MISS : plt_pkg::S_CMP;
                end
            end
            plt_pkg::S_CMP: begin
                priority if (i_stat.match) n_state = plt_pkg::S_DONE;
                else if (i_stat.more)      n_state = plt_pkg::S_CMP;
                else                       n_state = plt_pkg::S_MISS;
            end
            plt_pkg::S_MISS:  n_state = plt_pkg::S_DONE;
            plt_pkg::S_RDATA: n_state = plt_pkg::S_DONE;
            plt_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = plt_pkg::S_IDLE;
            end
            default: n_state = plt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = 1'b0;
        o_cmd.latch      = 1'b0;
        o_cmd.rd         = 1'b0;
        o_cmd.idx_inc    = 1'b0;
        o_cmd.wr_hit     = 1'b0;
        o_cmd.wr_new     = 1'b0;
        o_cmd.res        = plt_pkg::RES_NONE;
        o_cmd.load_out   = 1'b0;
        unique case (r_state)
            plt_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.latch = i_valid;
            end
            plt_pkg::S_LOOK: begin
                if (i_stat.is_read) begin
                    if (i_stat.in_range) o_cmd.rd = 1'b1;
                    else                 o_cmd.res = plt_pkg::RES_READ_EMPTY;
                end else if (!i_stat.fill_zero) begin
                    o_cmd.rd = 1'b1;
                end
            end
            plt_pkg::S_CMP: begin
                priority if (i_stat.match) begin
                    o_cmd.wr_hit = 1'b1;
                    o_cmd.res    = plt_pkg::RES_UPDATED;
                end else if (i_stat.more) begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            plt_pkg::S_MISS: begin
                if (i_stat.room) begin
                    o_cmd.wr_new = 1'b1;
                    o_cmd.res    = plt_pkg::RES_INSERTED;
                end else begin
                    o_cmd.res = plt_pkg::RES_FULL;
                end
            end
            plt_pkg::S_RDATA: o_cmd.res = plt_pkg::RES_READ_OK;
            plt_pkg::S_DONE:  o_cmd.load_out = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

### src/peer_learning_table.sv
// learning table of heard senders, up to 32 entries held in one registered-read ram.
// an observe word (tuser = 0) scans the filled entries one per cycle; on a hit it
// rewrites that entry's strength and last-seen time, on a miss it appends a new entry
// or reports the table full; a read word (tuser = 1) returns the entry at read_index,
// or status read-empty when the index is at or above the fill count. every input word
// gives exactly one output word. entries are never removed and the fill count is
// zero after reset. a read fetches its entry from the ram for the result, or goes
// straight to the result when past the fill count; an observe compares the filled
// entries in order up to a hit or the last one, and on a miss then appends or reports
// full. one word is in flight at a time, as the lookup loop walks the single ram read
// port. the input is ready again in the cycle after the result loads, so a stalled
// output side lets one more word through to its result, which then holds off input.
module peer_learning_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // source_address[47:0], signal_strength[55:48], timestamp_ms[87:56],
    // read_index[92:88], zero fill [95:93]
    input  logic [95:0]   i_s_axis_tdata,
    // opcode[0]
    input  logic          i_s_axis_tuser,
    // result stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // entry_index[4:0], entry_address[52:5], entry_strength[60:53],
    // entry_last_seen[92:61], fill_count[98:93], zero fill [103:99]
    output logic [103:0]  o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]    o_m_axis_tuser
);

    plt_pkg::t_cmd   cmd;
    plt_pkg::t_stat  stat;

    logic [plt_pkg::STATUS_W-1:0]        res_status;
    logic [plt_pkg::IDX_W-1:0]           res_index;
    logic [plt_pkg::ADDR_W-1:0]          res_addr;
    logic signed [plt_pkg::STR_W-1:0]    res_str;
    logic [plt_pkg::SEEN_W-1:0]          res_seen;
    logic [plt_pkg::FILL_W-1:0]          res_fill;

    // sequencer: accept, lookup loop, write, hand off to output register
    plt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // item registers, fill count, entry ram, result and output registers
    plt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_s_axis_tuser),
        .i_addr      (i_s_axis_tdata[47:0]),
        .i_str       (i_s_axis_tdata[55:48]),
        .i_seen      (i_s_axis_tdata[87:56]),
        .i_ridx      (i_s_axis_tdata[92:88]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_status    (res_status),
        .o_index     (res_index),
        .o_addr      (res_addr),
        .o_str       (res_str),
        .o_seen      (res_seen),
        .o_fill      (res_fill)
    );

    // pack the result word, lowest field first
    assign o_m_axis_tdata = {5'b0, res_fill, res_seen, res_str, res_addr, res_index};
    assign o_m_axis_tuser = res_status;

    // one item in flight: no accept in the cycle after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while an item is in progress");

    // an inserted entry is always the last filled one
    a_insert_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && res_status == plt_pkg::ST_INSERTED)
            |-> ({1'b0, res_index} + 6'd1 == res_fill))
        else $error("inserted index does not match fill count");

    // dropping only happens on a full table
    a_full_only_at_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && res_status == plt_pkg::ST_FULL)
            |-> (res_fill == plt_pkg::FILL_W'(plt_pkg::TABLE_DEPTH)))
        else $error("full reported below table depth");

    // fill count never exceeds the table depth and status codes stay defined
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (res_fill <= plt_pkg::FILL_W'(plt_pkg::TABLE_DEPTH)
            && res_status <= plt_pkg::ST_READ_EMPTY))
        else $error("fill count or status out of range");

endmodule

### bench/tb_peer_learning_table.sv
`timescale 1ns / 100ps

module tb_peer_learning_table;

    localparam int HALF_PERIOD  = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 40;

    // one expected result word, fields as the block reports them
    typedef struct packed {
        logic [plt_pkg::STATUS_W-1:0]  status;
        logic [plt_pkg::IDX_W-1:0]     index;
        logic [plt_pkg::ADDR_W-1:0]    addr;
        logic [plt_pkg::STR_W-1:0]     strength;
        logic [plt_pkg::SEEN_W-1:0]    seen;
        logic [plt_pkg::FILL_W-1:0]    fill;
    } t_result;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [95:0]  s_data = '0;
    logic         s_user = 1'b0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [103:0] m_data;
    logic [2:0]   m_user;

    // shadow copy of the table
    logic [plt_pkg::ADDR_W-1:0]        shadow_addr [plt_pkg::TABLE_DEPTH];
    logic signed [plt_pkg::STR_W-1:0]  shadow_str  [plt_pkg::TABLE_DEPTH];
    logic [plt_pkg::SEEN_W-1:0]        shadow_seen [plt_pkg::TABLE_DEPTH];
    int                                shadow_fill = 0;

    t_result pending_results [$];
    t_result arrived;
    int      errors = 0;
    bit      steady_src = 1'b0;
    bit      hold_req = 1'b0;
    bit      hold_active = 1'b0;

    peer_learning_table dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always #HALF_PERIOD clk = ~clk;

    // read, or lookup then update or append, the way the table should behave
    function automatic t_result learn_predict(input logic op,
                                              input logic [plt_pkg::ADDR_W-1:0] a,
                                              input logic [plt_pkg::STR_W-1:0] s,
                                              input logic [plt_pkg::SEEN_W-1:0] t,
                                              input logic [plt_pkg::IDX_W-1:0] ri);
        t_result r;
        int hit;
        r = '0;
        hit = -1;
        if (op == plt_pkg::OP_READ) begin
            r.index = ri;
            if (int'(ri) < shadow_fill) begin
                r.status   = plt_pkg::ST_READ_OK;
                r.addr     = shadow_addr[ri];
                r.strength = shadow_str[ri];
                r.seen     = shadow_seen[ri];
            end else begin
                r.status = plt_pkg::ST_READ_EMPTY;
            end
        end else begin
            for (int k = 0; k < shadow_fill; k++) begin
                if (hit < 0 && shadow_addr[k] == a) hit = k;
            end
            if (hit >= 0) begin
                shadow_str[hit]  = s;
                shadow_seen[hit] = t;
                r.status   = plt_pkg::ST_UPDATED;
                r.index    = plt_pkg::IDX_W'(hit);
                r.addr     = shadow_addr[hit];
                r.strength = s;
                r.seen     = t;
            end else if (shadow_fill < plt_pkg::TABLE_DEPTH) begin
                shadow_addr[shadow_fill] = a;
                shadow_str[shadow_fill]  = s;
                shadow_seen[shadow_fill] = t;
                r.status   = plt_pkg::ST_INSERTED;
                r.index    = plt_pkg::IDX_W'(shadow_fill);
                r.addr     = a;
                r.strength = s;
                r.seen     = t;
                shadow_fill++;
            end else begin
                r.status = plt_pkg::ST_FULL;
            end
        end
        r.fill = plt_pkg::FILL_W'(shadow_fill);
        return r;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [plt_pkg::ADDR_W-1:0] random_address();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // an address that is surely not in the table
    function automatic logic [plt_pkg::ADDR_W-1:0] fresh_address();
        logic [plt_pkg::ADDR_W-1:0] a;
        bit found;
        do begin
            a = random_address();
            found = 1'b0;
            for (int k = 0; k < shadow_fill; k++) begin
                if (shadow_addr[k] == a) found = 1'b1;
            end
        end while (found);
        return a;
    endfunction

    // offer one word, wait for the handshake, queue what it should produce
    task automatic send_word(input logic op, input logic [plt_pkg::ADDR_W-1:0] a,
                             input logic [plt_pkg::STR_W-1:0] s,
                             input logic [plt_pkg::SEEN_W-1:0] t,
                             input logic [plt_pkg::IDX_W-1:0] ri);
        int gap;
        gap = steady_src ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {3'b000, ri, t, s, a};
        s_user  <= op;
        do @(posedge clk); while (!s_ready);
        pending_results.push_back(learn_predict(op, a, s, t, ri));
        @(negedge clk);
    endtask

    // one random word: reads, hits, near misses and fresh addresses
    task automatic random_item();
        int pick;
        logic [plt_pkg::ADDR_W-1:0] a;
        pick = $urandom_range(0, 99);
        a = random_address();
        if (pick < 25) begin
            send_word(plt_pkg::OP_READ, a, 8'($urandom()), $urandom(), 5'($urandom()));
        end else begin
            if (shadow_fill > 0 && pick < 70) begin
                a = shadow_addr[$urandom_range(0, shadow_fill - 1)];
            end else if (shadow_fill > 0 && pick < 82) begin
                // one bit away from a stored address
                a = shadow_addr[$urandom_range(0, shadow_fill - 1)];
                a[$urandom_range(0, plt_pkg::ADDR_W - 1)] ^= 1'b1;
            end
            send_word(plt_pkg::OP_OBSERVE, a, 8'($urandom()), $urandom(),
                      5'($urandom()));
        end
    endtask

    task automatic test_empty_reads();
        send_word(plt_pkg::OP_READ, '0, '0, '0, 5'd0);
        send_word(plt_pkg::OP_READ, '1, '1, '1, 5'd31);
    endtask

    task automatic test_observe_extremes();
        send_word(plt_pkg::OP_OBSERVE, '0, 8'h80, 32'h0000_0000, 5'd0);
        send_word(plt_pkg::OP_OBSERVE, '1, 8'h7f, 32'hffff_ffff, 5'd31);
        // hit on the first entry rewrites strength and time
        send_word(plt_pkg::OP_OBSERVE, '0, 8'h7f, 32'hffff_ffff, 5'd17);
        // lowest bit differs from entry 0: must append, not hit
        send_word(plt_pkg::OP_OBSERVE, 48'h0000_0000_0001, 8'hff, 32'h1234_5678, 5'd3);
        send_word(plt_pkg::OP_READ, '0, '0, '0, 5'd0);
        send_word(plt_pkg::OP_READ, '0, '0, '0, 5'd1);
        send_word(plt_pkg::OP_READ, '0, '0, '0, 5'd2);
        send_word(plt_pkg::OP_READ, '0, '0, '0, 5'd3);
        send_word(plt_pkg::OP_READ, '1, '1, '1, 5'd31);
    endtask

    task automatic test_random_learning(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) steady_src = ($urandom_range(0, 3) == 0);
            random_item();
        end
        steady_src = 1'b0;
    endtask

    // receiver stops for a long stretch while words keep coming
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        while (!hold_active) @(negedge clk);
        steady_src = 1'b1;
        for (int n = 0; n < 12; n++) random_item();
        steady_src = 1'b0;
    endtask

    task automatic test_table_full();
        while (shadow_fill < plt_pkg::TABLE_DEPTH) begin
            send_word(plt_pkg::OP_OBSERVE, fresh_address(), 8'($urandom()), $urandom(), '0);
        end
        // miss on a full table is dropped
        send_word(plt_pkg::OP_OBSERVE, fresh_address(), 8'h80, 32'hffff_ffff, 5'd31);
        // hit on the very last entry still works
        send_word(plt_pkg::OP_OBSERVE, shadow_addr[plt_pkg::TABLE_DEPTH-1], 8'hff,
                  32'h8000_0000, '0);
        send_word(plt_pkg::OP_READ, '0, '0, '0, 5'd31);
        send_word(plt_pkg::OP_READ, '1, '1, '1, 5'd0);
    endtask

    task automatic test_random_full(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) steady_src = ($urandom_range(0, 3) == 0);
            random_item();
        end
        steady_src = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            errors++;
        end
    endtask

    // result side ready pattern, plus the long hold when asked
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_active = 1'b0;
                hold_req = 1'b0;
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                if (pick_gap() > 0) begin
                    m_ready <= 1'b0;
                    repeat (pick_gap() + 1) @(negedge clk);
                end
            end
        end
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: tuser %h tdata %h", m_user, m_data);
                errors++;
            end else begin
                arrived = pending_results.pop_front();
                check_field("status", 64'(arrived.status), 64'(m_user));
                check_field("entry_index", 64'(arrived.index), 64'(m_data[4:0]));
                check_field("entry_address", 64'(arrived.addr), 64'(m_data[52:5]));
                check_field("entry_strength", 64'(arrived.strength), 64'(m_data[60:53]));
                check_field("entry_last_seen", 64'(arrived.seen), 64'(m_data[92:61]));
                check_field("fill_count", 64'(arrived.fill), 64'(m_data[98:93]));
            end
        end
    end

    initial begin
        int drain;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_reads();
        test_observe_extremes();
        test_random_learning(250);
        test_output_backpressure();
        test_table_full();
        test_random_full(340);
        s_valid <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
